// File: rtl/assert_macros.svh
// Assertion macros shared by the hit-merge table RTL.
// Assertions compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: rtl/chmt_pkg.sv
// Package of the calorimeter hit-merge table: sizes, payload types and states.
// No dependencies.
package chmt_pkg;
   localparam int MaxHits   = 4096;
   localparam int NumTowers = 32768;
   localparam int SlotW     = $clog2(MaxHits);
   localparam int CountW    = $clog2(MaxHits + 1);
   localparam int TowerW    = $clog2(NumTowers);
   localparam int FifoDepth = 2;

   typedef enum logic {FUNC_MERGE = 1'b0, FUNC_CLEAR = 1'b1} func_type;

   typedef struct packed {
      logic        func;
      logic [14:0] tower_id;
      logic signed [31:0] energy;
      logic signed [31:0] hit_time;
      logic [31:0] dead_mask;
      logic [31:0] warn_mask;
      logic [17:0] soft_key;
   } req_type;

   typedef struct packed {
      logic [11:0] slot;
      logic        was_new;
      logic        dropped;
      logic signed [31:0] energy_sum;
      logic signed [31:0] time_min;
      logic [31:0] dead_or;
      logic [31:0] warn_or;
      logic [17:0] key_out;
      logic [12:0] hit_count;
   } rsp_type;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE} back_state_type;

   function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      if (a[31] == b[31] && s[31] != a[31])
         return a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return s;
   endfunction
endpackage

// File: rtl/chmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module chmt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/chmt_front.sv
// Front part: accepts items, marks out-of-range towers, and queues them.
// Depends on chmt_pkg.
module chmt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  chmt_pkg::req_type  req_data,
   output logic               q_valid,
   input  logic               q_pop,
   output chmt_pkg::req_type  q_data,
   output logic               q_oor
);
   import chmt_pkg::*;

   localparam int PtrW = $clog2(FifoDepth);

   req_type        buf_ff [FifoDepth];
   logic           oor_ff [FifoDepth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]  cnt_ff, cnt_in;
   logic           push;

   // Tower ids wider than the index range are dropped by the back part.
   logic oor;
   assign oor = ({1'b0, req_data.tower_id} >= (TowerW + 1)'(NumTowers));

   assign req_stall = (cnt_ff == (PtrW + 1)'(FifoDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = buf_ff[rd_ff];
   assign q_oor     = oor_ff[rd_ff];

   always_comb begin
      wr_in  = push  ? wr_ff + 1'b1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrW + 1)'(push) - (PtrW + 1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wr_ff] <= req_data;
         oor_ff[wr_ff] <= oor;
      end
   end
endmodule

// File: rtl/chmt_back.sv
// Back part: sparse-set lookup and read-modify-write of the slot memories.
// Depends on chmt_pkg and chmt_ram.
module chmt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  chmt_pkg::req_type q_data,
   input  logic              q_oor,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chmt_pkg::rsp_type rsp_data,
   output logic [chmt_pkg::CountW-1:0] count
);
   import chmt_pkg::*;

   typedef struct packed {
      logic [TowerW-1:0] tower;
      logic signed [31:0] energy;
      logic signed [31:0] tm;
      logic [31:0] dead;
      logic [31:0] warn;
      logic [17:0] key;
   } slot_rec_type;

   back_state_type state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   req_type  item_ff, item_in;
   logic     oor_ff, oor_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   logic [SlotW-1:0] sot_rd, sot_wr_data;
   logic             sot_we;
   slot_rec_type     rec_rd, rec_wr;
   logic             rec_we;
   logic [SlotW-1:0] rec_addr_wr;
   logic             out_free, hit;

   // Slot memory is read at the index output; its read data is registered and arrives in the next cycle.
   chmt_ram #(.Width(SlotW), .Depth(NumTowers)) u_sot (
      .clock(clock), .wr_en(sot_we), .wr_addr(item_ff.tower_id[TowerW-1:0]),
      .wr_data(sot_wr_data), .rd_addr(q_data.tower_id[TowerW-1:0]), .rd_data(sot_rd));

   // While a result waits, the record read is held on the captured slot.
   logic [SlotW-1:0] s_ptr_ff;
   chmt_ram #(.Width($bits(slot_rec_type)), .Depth(MaxHits)) u_rec (
      .clock(clock), .wr_en(rec_we), .wr_addr(rec_addr_wr), .wr_data(rec_wr),
      .rd_addr((state_ff == ST_READ) ? sot_rd : s_ptr_ff), .rd_data(rec_rd));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign count     = count_ff;

   // Hit test reads the record addressed by the registered index read.
   assign hit = ({1'b0, s_ptr_ff} < count_ff) && (rec_rd.tower == item_ff.tower_id[TowerW-1:0]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = (state_ff == ST_IDLE) && q_valid;
      item_in      = q_pop ? q_data : item_ff;
      oor_in       = q_pop ? q_oor : oor_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      sot_we       = 1'b0;
      sot_wr_data  = count_ff[SlotW-1:0];
      rec_we       = 1'b0;
      rec_addr_wr  = s_ptr_ff;
      rec_wr       = rec_rd;
      if (state_ff == ST_WRITE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (item_ff.func == FUNC_CLEAR) begin
            count_in = '0;
         end else if (!oor_ff && hit) begin
            rec_we          = 1'b1;
            rec_wr.energy   = sat_add(rec_rd.energy, item_ff.energy);
            rec_wr.tm       = (item_ff.hit_time < rec_rd.tm) ? item_ff.hit_time : rec_rd.tm;
            rec_wr.dead     = rec_rd.dead | item_ff.dead_mask;
            rec_wr.warn     = rec_rd.warn | item_ff.warn_mask;
            rec_wr.key      = (rec_rd.key == '0) ? item_ff.soft_key : rec_rd.key;
            rsp_in.slot     = 12'(s_ptr_ff);
            rsp_in.energy_sum = rec_wr.energy;
            rsp_in.time_min = rec_wr.tm;
            rsp_in.dead_or  = rec_wr.dead;
            rsp_in.warn_or  = rec_wr.warn;
            rsp_in.key_out  = rec_wr.key;
         end else begin
            rsp_in.energy_sum = item_ff.energy;
            rsp_in.time_min   = item_ff.hit_time;
            rsp_in.dead_or    = item_ff.dead_mask;
            rsp_in.warn_or    = item_ff.warn_mask;
            rsp_in.key_out    = item_ff.soft_key;
            if (!oor_ff && count_ff < CountW'(MaxHits)) begin
               sot_we        = 1'b1;
               rec_we        = 1'b1;
               rec_addr_wr   = count_ff[SlotW-1:0];
               rec_wr.tower  = item_ff.tower_id[TowerW-1:0];
               rec_wr.energy = item_ff.energy;
               rec_wr.tm     = item_ff.hit_time;
               rec_wr.dead   = item_ff.dead_mask;
               rec_wr.warn   = item_ff.warn_mask;
               rec_wr.key    = item_ff.soft_key;
               rsp_in.slot   = 12'(count_ff[SlotW-1:0]);
               rsp_in.was_new = 1'b1;
               count_in      = count_ff + 1'b1;
            end else begin
               rsp_in.dropped = 1'b1;
            end
         end
         rsp_in.hit_count = 13'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      oor_ff  <= oor_in;
      rsp_ff  <= rsp_in;
      if (state_ff == ST_IDLE) s_ptr_ff <= s_ptr_ff;
      if (state_ff == ST_READ) s_ptr_ff <= sot_rd;
   end
endmodule

// File: rtl/calorimeter_hit_merge_table_top.sv
// Top level of the calorimeter hit-merge table.
// Depends on chmt_pkg, chmt_front, chmt_back and assert_macros.svh.
//
// The block merges tower hits into a table of up to 4096 slots. Each item
// yields exactly one result item. The front part takes items into a two-entry
// queue; the back part does a read-modify-write of the slot memories for
// each item in steps (index read, slot read, write and result) and pops the
// next item only when through with the last; the write step waits while
// the result is stalled. A clear item empties the table at once; the memories
// are never swept, since the hit test checks the slot count and back-pointer.
`include "assert_macros.svh"
module calorimeter_hit_merge_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  chmt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chmt_pkg::rsp_type rsp_data
);
   import chmt_pkg::*;

   logic    q_valid, q_pop, q_oor;
   req_type q_data;
   logic [CountW-1:0] count;

   chmt_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
      .q_oor(q_oor));

   chmt_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_data(q_data), .q_oor(q_oor), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data), .count(count));

   // The slot count never passes the table size.
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count <= CountW'(MaxHits))
   // A new tower and a dropped hit are never reported together.
   `ASSERT_IMPLIES(a_new_xor_drop, clock, reset, rsp_valid, !(rsp_data.was_new && rsp_data.dropped))
   // The queue is never popped when empty.
   `ASSERT_IMPLIES(a_pop_valid, clock, reset, q_pop, q_valid)
endmodule
